FILE: rtl/fdc_pkg.sv
// Package for the frame deframer with CRC-16 check.
// Holds constants, status codes, the queue entry type and the CRC byte update.
// No dependencies.
package fdc_pkg;

  localparam int MAX_PAYLOAD_BYTES = 64;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [8:0] POS_SYNC0  = 9'd0;
  localparam logic [8:0] POS_SYNC1  = 9'd1;
  localparam logic [8:0] POS_SRC    = 9'd2;
  localparam logic [8:0] POS_DST    = 9'd3;
  localparam logic [8:0] POS_TYPE   = 9'd4;
  localparam logic [8:0] POS_MID_LO = 9'd5;
  localparam logic [8:0] POS_MID_HI = 9'd6;
  localparam logic [8:0] POS_PAY    = 9'd9;
  localparam logic [8:0] POS_MAX    = 9'd511;
  localparam logic [8:0] POS_LIMIT  = 9'(9 + MAX_PAYLOAD_BYTES);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  typedef enum logic [2:0] {
    FS_OK       = 3'd0,
    FS_SHORT    = 3'd1,
    FS_BAD_SYNC = 3'd2,
    FS_TOO_LONG = 3'd3,
    FS_CRC_BAD  = 3'd4
  } frame_status_t;

  typedef struct packed {
    logic          has_pay;
    logic [7:0]    pay_byte;
    logic [5:0]    pay_idx;
    logic          has_end;
    logic [7:0]    source_addr;
    logic [7:0]    dest_addr;
    logic [7:0]    message_type;
    logic [15:0]   message_id;
    logic [7:0]    payload_count;
    logic [15:0]   received_crc;
    frame_status_t status;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/fdc_ifs.sv
// Channel interfaces of the frame deframer: received bytes in, results out.
// Depends on nothing.
interface fdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;
  modport source (output valid, rx_byte, frame_end, input ready);
  modport sink (input valid, rx_byte, frame_end, output ready);
endinterface

interface fdc_out_if;
  logic        valid;
  logic        ready;
  logic        is_end;
  logic [7:0]  payload_byte;
  logic [5:0]  payload_index;
  logic [7:0]  source_addr;
  logic [7:0]  dest_addr;
  logic [7:0]  message_type;
  logic [15:0] message_id;
  logic [7:0]  payload_count;
  logic [15:0] received_crc;
  logic [2:0]  frame_status;
  modport source (output valid, is_end, payload_byte, payload_index, source_addr, dest_addr,
                  message_type, message_id, payload_count, received_crc, frame_status,
                  input ready);
  modport sink (input valid, is_end, payload_byte, payload_index, source_addr, dest_addr,
                message_type, message_id, payload_count, received_crc, frame_status,
                output ready);
endinterface

FILE: rtl/frame_deframer_crc16_check.sv
// Top level of the frame deframer with CRC-16 check.
// Uses fdc_pkg, fdc_ifs, fdc_front, fdc_queue, fdc_back.
//
// Accepts one received byte per clock. Each byte passes through a two-byte
// hold and an unrolled 8-bit CRC-16 update in the front end, so a steady
// stream runs at one byte per cycle. A payload transaction is written to the
// queue at the edge that accepts the byte pushing it out of the hold and
// leaves through the back end's output register; the final byte of a frame
// may give a payload and the status transaction, which leave in that order.
// A four-entry queue between front and back end absorbs output stalls; the
// input stalls only when that queue is full. Sync bytes are set on the cfg port
// by the user only while idle, which the block does not enforce; no clearing pass after reset.
module frame_deframer_crc16_check (
  input  logic       clk,
  input  logic       rst_n,
  fdc_in_if.sink     in_ch,
  fdc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  fdc_pkg::entry_t  q_entry, q_head;
  fdc_pkg::q_stat_t q_stat;
  logic             q_push, q_pop;

  fdc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  fdc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  fdc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .q_stat (q_stat),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into full queue");

  a_pay_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.is_end |-> out_ch.frame_status == 3'(fdc_pkg::FS_OK) &&
      out_ch.payload_count == 8'd0)
    else $error("payload transaction carries status fields");

  a_ok_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_end && out_ch.frame_status == 3'(fdc_pkg::FS_OK) |->
      out_ch.payload_count <= 8'(fdc_pkg::MAX_PAYLOAD_BYTES))
    else $error("ok status with oversize payload");

endmodule

FILE: rtl/fdc_front.sv
// Front end: accepts bytes, tracks frame position, header, hold and CRC,
// and pushes one queue entry per byte that yields results. Uses fdc_pkg, fdc_in_if.
module fdc_front (
  input  logic             clk,
  input  logic             rst_n,
  fdc_in_if.sink           in_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_wdata,
  input  fdc_pkg::q_stat_t q_stat,
  output logic             q_push,
  output fdc_pkg::entry_t  q_entry
);

  logic [7:0]  sync_first_r, sync_second_r;
  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  held0_r, held0_nxt, held1_r, held1_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  src_r, src_nxt, dst_r, dst_nxt, typ_r, typ_nxt;
  logic [15:0] mid_r, mid_nxt;
  logic        sync_ok_r, sync_ok_nxt;

  logic        acc, last, emit_pay;
  logic [7:0]  b;
  logic [7:0]  src_c, dst_c, typ_c;
  logic [15:0] mid_c, crc_c, rcrc;
  logic        sync_c;
  logic [9:0]  len, plen;
  logic [8:0]  idx9;
  fdc_pkg::frame_status_t status;

  assign in_ch.ready = !q_stat.full;
  assign acc  = in_ch.valid && in_ch.ready;
  assign b    = in_ch.rx_byte;
  assign last = in_ch.frame_end;

  always_comb begin
    src_c  = src_r;
    dst_c  = dst_r;
    typ_c  = typ_r;
    mid_c  = mid_r;
    sync_c = sync_ok_r;
    case (pos_r)
      fdc_pkg::POS_SYNC0:  sync_c = sync_ok_r && (b == sync_first_r);
      fdc_pkg::POS_SYNC1:  sync_c = sync_ok_r && (b == sync_second_r);
      fdc_pkg::POS_SRC:    src_c = b;
      fdc_pkg::POS_DST:    dst_c = b;
      fdc_pkg::POS_TYPE:   typ_c = b;
      fdc_pkg::POS_MID_LO: mid_c = {mid_r[15:8], b};
      fdc_pkg::POS_MID_HI: mid_c = {b, mid_r[7:0]};
      default: ;
    endcase

    crc_c    = (pos_r >= fdc_pkg::POS_SRC) ? fdc_pkg::crc16_byte(crc_r, held0_r) : crc_r;
    emit_pay = (pos_r >= fdc_pkg::POS_PAY) && (pos_r < fdc_pkg::POS_LIMIT) && sync_c;
    idx9     = pos_r - fdc_pkg::POS_PAY;
    len      = {1'b0, pos_r} + 10'd1;
    plen     = (len >= 10'd9) ? (len - 10'd9) : 10'd0;
    rcrc     = {b, held1_r};

    if (len < 10'd9) begin
      status = fdc_pkg::FS_SHORT;
    end else if (!sync_c) begin
      status = fdc_pkg::FS_BAD_SYNC;
    end else if (plen > 10'(fdc_pkg::MAX_PAYLOAD_BYTES)) begin
      status = fdc_pkg::FS_TOO_LONG;
    end else if (crc_c != rcrc) begin
      status = fdc_pkg::FS_CRC_BAD;
    end else begin
      status = fdc_pkg::FS_OK;
    end

    q_entry.has_pay       = emit_pay;
    q_entry.pay_byte      = held0_r;
    q_entry.pay_idx       = idx9[5:0];
    q_entry.has_end       = last;
    q_entry.source_addr   = src_c;
    q_entry.dest_addr     = dst_c;
    q_entry.message_type  = typ_c;
    q_entry.message_id    = mid_c;
    q_entry.payload_count = (plen > 10'd255) ? 8'hFF : plen[7:0];
    q_entry.received_crc  = rcrc;
    q_entry.status        = status;
    q_push = acc && (emit_pay || last);

    pos_nxt     = pos_r;
    held0_nxt   = held0_r;
    held1_nxt   = held1_r;
    crc_nxt     = crc_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    typ_nxt     = typ_r;
    mid_nxt     = mid_r;
    sync_ok_nxt = sync_ok_r;
    if (acc) begin
      if (last) begin
        pos_nxt     = '0;
        held0_nxt   = '0;
        held1_nxt   = '0;
        crc_nxt     = fdc_pkg::CRC_INIT;
        src_nxt     = '0;
        dst_nxt     = '0;
        typ_nxt     = '0;
        mid_nxt     = '0;
        sync_ok_nxt = 1'b1;
      end else begin
        pos_nxt     = (pos_r == fdc_pkg::POS_MAX) ? pos_r : pos_r + 9'd1;
        held0_nxt   = held1_r;
        held1_nxt   = b;
        crc_nxt     = crc_c;
        src_nxt     = src_c;
        dst_nxt     = dst_c;
        typ_nxt     = typ_c;
        mid_nxt     = mid_c;
        sync_ok_nxt = sync_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= '0;
      sync_second_r <= '0;
      pos_r         <= '0;
      held0_r       <= '0;
      held1_r       <= '0;
      crc_r         <= fdc_pkg::CRC_INIT;
      src_r         <= '0;
      dst_r         <= '0;
      typ_r         <= '0;
      mid_r         <= '0;
      sync_ok_r     <= 1'b1;
    end else begin
      if (cfg_we && cfg_index == fdc_pkg::REG_SYNC_FIRST) begin
        sync_first_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == fdc_pkg::REG_SYNC_SECOND) begin
        sync_second_r <= cfg_wdata;
      end
      pos_r     <= pos_nxt;
      held0_r   <= held0_nxt;
      held1_r   <= held1_nxt;
      crc_r     <= crc_nxt;
      src_r     <= src_nxt;
      dst_r     <= dst_nxt;
      typ_r     <= typ_nxt;
      mid_r     <= mid_nxt;
      sync_ok_r <= sync_ok_nxt;
    end
  end

endmodule

FILE: rtl/fdc_queue.sv
// Short FIFO of result entries between front and back end.
// Uses fdc_pkg.
module fdc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fdc_pkg::entry_t  push_entry,
  input  logic             pop,
  output fdc_pkg::entry_t  head,
  output fdc_pkg::q_stat_t stat
);

  fdc_pkg::entry_t mem [fdc_pkg::QDEPTH];
  logic [fdc_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [fdc_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign stat.full  = (cnt_r == fdc_pkg::QCNT_W'(fdc_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/fdc_back.sv
// Back end: expands queue entries into payload and status transactions
// through a registered output stage. Uses fdc_pkg, fdc_out_if.
module fdc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  fdc_pkg::entry_t  head,
  input  fdc_pkg::q_stat_t q_stat,
  output logic             pop,
  fdc_out_if.source        out_ch
);

  logic        valid_r, valid_nxt;
  logic        phase_r, phase_nxt;
  logic        is_end_r, is_end_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;
  logic [5:0]  pidx_r, pidx_nxt;
  logic [7:0]  src_r, src_nxt, dst_r, dst_nxt, typ_r, typ_nxt, cnt_r, cnt_nxt;
  logic [15:0] mid_r, mid_nxt, rcrc_r, rcrc_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic        load;

  assign load = !q_stat.empty && (!valid_r || out_ch.ready);

  always_comb begin
    pop        = 1'b0;
    phase_nxt  = phase_r;
    valid_nxt  = valid_r && !out_ch.ready;
    is_end_nxt = is_end_r;
    pbyte_nxt  = pbyte_r;
    pidx_nxt   = pidx_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    typ_nxt    = typ_r;
    mid_nxt    = mid_r;
    cnt_nxt    = cnt_r;
    rcrc_nxt   = rcrc_r;
    stat_nxt   = stat_r;
    if (load) begin
      valid_nxt = 1'b1;
      if (head.has_pay && !phase_r) begin
        is_end_nxt = 1'b0;
        pbyte_nxt  = head.pay_byte;
        pidx_nxt   = head.pay_idx;
        src_nxt    = '0;
        dst_nxt    = '0;
        typ_nxt    = '0;
        mid_nxt    = '0;
        cnt_nxt    = '0;
        rcrc_nxt   = '0;
        stat_nxt   = '0;
        phase_nxt  = head.has_end;
        pop        = !head.has_end;
      end else begin
        is_end_nxt = 1'b1;
        pbyte_nxt  = '0;
        pidx_nxt   = '0;
        src_nxt    = head.source_addr;
        dst_nxt    = head.dest_addr;
        typ_nxt    = head.message_type;
        mid_nxt    = head.message_id;
        cnt_nxt    = head.payload_count;
        rcrc_nxt   = head.received_crc;
        stat_nxt   = head.status;
        phase_nxt  = 1'b0;
        pop        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_end_r <= is_end_nxt;
    pbyte_r  <= pbyte_nxt;
    pidx_r   <= pidx_nxt;
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    typ_r    <= typ_nxt;
    mid_r    <= mid_nxt;
    cnt_r    <= cnt_nxt;
    rcrc_r   <= rcrc_nxt;
    stat_r   <= stat_nxt;
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.is_end        = is_end_r;
  assign out_ch.payload_byte  = pbyte_r;
  assign out_ch.payload_index = pidx_r;
  assign out_ch.source_addr   = src_r;
  assign out_ch.dest_addr     = dst_r;
  assign out_ch.message_type  = typ_r;
  assign out_ch.message_id    = mid_r;
  assign out_ch.payload_count = cnt_r;
  assign out_ch.received_crc  = rcrc_r;
  assign out_ch.frame_status  = stat_r;

endmodule

FILE: test/tb_frame_deframer_crc16_check.sv
// Testbench for frame_deframer_crc16_check: sends directed and random frames,
// predicts payload and status transactions in a scoreboard class and checks them.
// Depends on fdc_pkg, fdc_ifs and the deframer RTL.
`timescale 1ns / 1ps

module tb_frame_deframer_crc16_check;
  import fdc_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 16;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES = 180;
  localparam int PHASE_BYTES = 60;

  typedef enum int {
    FLAW_NONE,
    FLAW_SYNC_FIRST,
    FLAW_SYNC_SECOND,
    FLAW_CRC
  } flaw_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  typedef struct packed {
    logic          is_end;
    logic [7:0]    pay_byte;
    logic [5:0]    pay_idx;
    logic [7:0]    src;
    logic [7:0]    dst;
    logic [7:0]    mtype;
    logic [15:0]   mid;
    logic [7:0]    count;
    logic [15:0]   rcrc;
    frame_status_t status;
  } frame_result_t;

  class frame_checker;
    logic [7:0]    sync_a;
    logic [7:0]    sync_b;
    logic [8:0]    pos;
    logic [7:0]    hold0;
    logic [7:0]    hold1;
    logic [15:0]   crc;
    logic [7:0]    src;
    logic [7:0]    dst;
    logic [7:0]    mtype;
    logic [15:0]   mid;
    bit            sync_ok;
    frame_result_t pending[$];
    int            errors;

    function new();
      sync_a = 8'h00;
      sync_b = 8'h00;
      errors = 0;
      clear_frame();
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
        fb = r[15] ^ b[i];
        r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
    endfunction

    function void clear_frame();
      pos = '0;
      hold0 = 8'h00;
      hold1 = 8'h00;
      crc = CRC_INIT;
      src = 8'h00;
      dst = 8'h00;
      mtype = 8'h00;
      mid = 16'h0000;
      sync_ok = 1'b1;
    endfunction

    function void set_sync(logic [7:0] first_val, logic [7:0] second_val);
      sync_a = first_val;
      sync_b = second_val;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      frame_result_t r;
      int            len;
      int            plen;
      logic [15:0]   rcrc;
      case (pos)
        POS_SYNC0:  if (b != sync_a) sync_ok = 1'b0;
        POS_SYNC1:  if (b != sync_b) sync_ok = 1'b0;
        POS_SRC:    src = b;
        POS_DST:    dst = b;
        POS_TYPE:   mtype = b;
        POS_MID_LO: mid[7:0] = b;
        POS_MID_HI: mid[15:8] = b;
        default: ;
      endcase
      // retire the oldest held byte into the CRC, emit it if it is payload
      if (pos >= POS_SRC) begin
        crc = crc_step(crc, hold0);
        if (pos >= POS_PAY && sync_ok && pos < POS_LIMIT) begin
          r = '0;
          r.pay_byte = hold0;
          r.pay_idx = 6'(pos - POS_PAY);
          pending.push_back(r);
        end
      end
      if (last) begin
        len = int'(pos) + 1;
        plen = (len >= int'(POS_PAY)) ? len - int'(POS_PAY) : 0;
        rcrc = {b, hold1};
        r = '0;
        r.is_end = 1'b1;
        r.src = src;
        r.dst = dst;
        r.mtype = mtype;
        r.mid = mid;
        r.count = (plen > 255) ? 8'hFF : 8'(plen);
        r.rcrc = rcrc;
        if (len < int'(POS_PAY)) r.status = FS_SHORT;
        else if (!sync_ok) r.status = FS_BAD_SYNC;
        else if (plen > MAX_PAYLOAD_BYTES) r.status = FS_TOO_LONG;
        else if (crc != rcrc) r.status = FS_CRC_BAD;
        else r.status = FS_OK;
        pending.push_back(r);
        clear_frame();
      end else begin
        hold0 = hold1;
        hold1 = b;
        if (pos != POS_MAX) pos = pos + 9'd1;
      end
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected transaction: expected none actual %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      check_field("is_end", want.is_end, got.is_end);
      check_field("payload_byte", want.pay_byte, got.pay_byte);
      check_field("payload_index", want.pay_idx, got.pay_idx);
      check_field("source_addr", want.src, got.src);
      check_field("dest_addr", want.dst, got.dst);
      check_field("message_type", want.mtype, got.mtype);
      check_field("message_id", want.mid, got.mid);
      check_field("payload_count", want.count, got.count);
      check_field("received_crc", want.rcrc, got.rcrc);
      check_field("frame_status", want.status, got.status);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;

  fdc_in_if  in_ch();
  fdc_out_if out_ch();

  frame_checker sb;
  int  bytes_sent = 0;
  int  idle_cycles = 0;
  bit  sender_gaps = 1'b0;
  bit  receiver_stalls = 1'b0;
  bit  hold_off_req = 1'b0;

  frame_deframer_crc16_check u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] fill_byte(fill_t fill);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return 8'($urandom_range(0, 255));
    endcase
  endfunction

  always @(posedge clk) begin : sample_edge
    frame_result_t seen;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_byte(in_ch.rx_byte, in_ch.frame_end);
        bytes_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.is_end = out_ch.is_end;
        seen.pay_byte = out_ch.payload_byte;
        seen.pay_idx = out_ch.payload_index;
        seen.src = out_ch.source_addr;
        seen.dst = out_ch.dest_addr;
        seen.mtype = out_ch.message_type;
        seen.mid = out_ch.message_id;
        seen.count = out_ch.payload_count;
        seen.rcrc = out_ch.received_crc;
        seen.status = frame_status_t'(out_ch.frame_status);
        sb.check_result(seen);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
      $display("FAIL frame_deframer_crc16_check");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (receiver_stalls && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle_len()) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = (sender_gaps && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.frame_end <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic send_frame(input int pay_len, input flaw_t flaw, input fill_t fill,
                            input int keep);
    logic [7:0]  fr[$];
    logic [15:0] crc;
    fr.push_back(sb.sync_a);
    fr.push_back(sb.sync_b);
    if (flaw == FLAW_SYNC_FIRST) fr[0] = fr[0] ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_SYNC_SECOND) fr[1] = fr[1] ^ 8'($urandom_range(1, 255));
    repeat (5 + pay_len) fr.push_back(fill_byte(fill));
    crc = CRC_INIT;
    foreach (fr[i]) crc = frame_checker::crc_step(crc, fr[i]);
    if (flaw == FLAW_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
    fr.push_back(crc[7:0]);
    fr.push_back(crc[15:8]);
    if (keep > 0) begin
      while (fr.size() > keep) void'(fr.pop_back());
    end
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 15) == 0));
    end
  endtask

  task automatic program_sync(input logic [7:0] first_val, input logic [7:0] second_val);
    cfg_we <= 1'b1;
    cfg_index <= REG_SYNC_FIRST;
    cfg_wdata <= first_val;
    @(negedge clk);
    cfg_index <= REG_SYNC_SECOND;
    cfg_wdata <= second_val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    sb.set_sync(first_val, second_val);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic sync_phase(input logic [7:0] first_val, input logic [7:0] second_val);
    drain();
    program_sync(first_val, second_val);
  endtask

  initial begin
    int rand_start;
    int phase_start;
    int pick;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SYNC_FIRST;
    cfg_wdata = 8'h00;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    in_ch.frame_end = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    program_sync(8'hFF, 8'hFF);

    send_frame(0, FLAW_NONE, FILL_ONES, 0);
    send_frame(0, FLAW_NONE, FILL_ZERO, 0);
    send_frame(4, FLAW_NONE, FILL_ONES, 0);
    send_frame(MAX_PAYLOAD_BYTES, FLAW_NONE, FILL_RANDOM, 0);
    send_frame(MAX_PAYLOAD_BYTES + 1, FLAW_NONE, FILL_RANDOM, 0);
    send_frame(3, FLAW_SYNC_FIRST, FILL_RANDOM, 0);
    send_frame(3, FLAW_SYNC_SECOND, FILL_RANDOM, 0);
    send_frame(5, FLAW_CRC, FILL_RANDOM, 0);
    send_frame(0, FLAW_NONE, FILL_RANDOM, 1);
    send_frame(0, FLAW_NONE, FILL_RANDOM, 2);
    send_frame(0, FLAW_NONE, FILL_RANDOM, 8);
    send_frame(0, FLAW_SYNC_FIRST, FILL_RANDOM, 5);
    send_frame(66, FLAW_CRC, FILL_RANDOM, 0);

    sync_phase(8'h00, 8'h00);
    send_frame(4, FLAW_NONE, FILL_ZERO, 0);
    hold_off_req = 1'b1;
    send_frame(40, FLAW_NONE, FILL_RANDOM, 0);
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;

    rand_start = bytes_sent;
    phase_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      if (bytes_sent - phase_start > PHASE_BYTES) begin
        sync_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        phase_start = bytes_sent;
      end
      if ($urandom_range(0, 7) == 0) begin
        sender_gaps = $urandom_range(0, 1);
        receiver_stalls = $urandom_range(0, 1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_frame(0, FLAW_NONE, FILL_RANDOM, $urandom_range(1, 8));
      end else if (pick < 14) begin
        send_noise($urandom_range(1, 12));
      end else if (pick < 20) begin
        send_frame($urandom_range(65, 80), FLAW_NONE, FILL_RANDOM, 0);
      end else if (pick < 30) begin
        send_frame($urandom_range(0, 20), (pick < 25) ? FLAW_SYNC_FIRST : FLAW_SYNC_SECOND,
                   FILL_RANDOM, 0);
      end else if (pick < 40) begin
        send_frame($urandom_range(0, 20), FLAW_CRC, FILL_RANDOM, 0);
      end else if (pick < 55) begin
        send_frame($urandom_range(17, MAX_PAYLOAD_BYTES), FLAW_NONE, FILL_RANDOM, 0);
      end else begin
        send_frame($urandom_range(0, 16), FLAW_NONE, FILL_RANDOM, 0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t %0d transaction(s) expected, none arrived", $time, sb.pending.size());
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS frame_deframer_crc16_check");
    end else begin
      $display("FAIL frame_deframer_crc16_check");
    end
    $finish;
  end

endmodule
